// ===== design/pipc_pkg.sv =====
// pipc_pkg: shared types and the edge crossing decision for the crossing-number test
// no dependencies; imported by every pipc module and the top level
`default_nettype none

package pipc_pkg;

	// control bits that travel with an item through the pipeline
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} pipc_ctl_t;

	// sign bits of both ends of one edge, taken after translation by the query point
	typedef struct packed {
		logic x1n;
		logic x2n;
		logic y1n;
		logic y2n;
	} edge_sign_t;

	// does the edge cross the closed positive x half-axis
	// a_ge_b / a_le_b compare x1*y2 against x2*y1
	function automatic logic edge_verdict(edge_sign_t s, logic a_ge_b, logic a_le_b);
		logic hit;
		hit = 1'b0;
		if (s.x1n && s.x2n) begin
			hit = 1'b0;
		end else if (s.y1n == s.y2n) begin
			hit = 1'b0;
		end else if (!s.x1n && !s.x2n) begin
			hit = 1'b1;
		end else if (s.y1n) begin
			// edge goes upward: intercept >= 0 when the cross term is >= 0
			hit = a_ge_b;
		end else begin
			hit = a_le_b;
		end
		return hit;
	endfunction

endpackage

`default_nettype wire

// ===== design/pipc_in_if.sv =====
// pipc_in_if: vertex channel with valid/ready handshake and query/vertex payload
// no dependencies
`default_nettype none

interface pipc_in_if #(
	parameter int COORD_BITS = 32
) ();
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] query_x;
	logic signed [COORD_BITS-1:0] query_y;
	logic signed [COORD_BITS-1:0] vertex_x;
	logic signed [COORD_BITS-1:0] vertex_y;
	logic                         first_vertex;
	logic                         last_vertex;

	modport source (
		output valid, query_x, query_y, vertex_x, vertex_y, first_vertex, last_vertex,
		input  ready
	);

	modport sink (
		input  valid, query_x, query_y, vertex_x, vertex_y, first_vertex, last_vertex,
		output ready
	);
endinterface

`default_nettype wire

// ===== design/pipc_out_if.sv =====
// pipc_out_if: result channel with valid/ready handshake and the inside flag
// no dependencies
`default_nettype none

interface pipc_out_if ();
	logic valid;
	logic ready;
	logic inside_res;

	modport source (
		output valid, inside_res,
		input  ready
	);

	modport sink (
		input  valid, inside_res,
		output ready
	);
endinterface

`default_nettype wire

// ===== design/pipc_front.sv =====
// pipc_front: input register, translation by the query point and the polygon state
// depends on pipc_pkg and pipc_in_if
`default_nettype none

module pipc_front import pipc_pkg::*; #(
	parameter int COORD_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	pipc_in_if.sink                     vtx,
	input  logic                        ready3,
	output pipc_ctl_t                   ctl_s2,
	output logic signed [COORD_BITS:0]  cur_x_s2,
	output logic signed [COORD_BITS:0]  cur_y_s2,
	output logic signed [COORD_BITS:0]  prv_x_s2,
	output logic signed [COORD_BITS:0]  prv_y_s2,
	output logic signed [COORD_BITS:0]  st_x_s2,
	output logic signed [COORD_BITS:0]  st_y_s2
);

	localparam int W = COORD_BITS + 1;

	pipc_ctl_t                    ctl_s1;
	logic signed [COORD_BITS-1:0] qx_s1, qy_s1, vx_s1, vy_s1;

	logic signed [COORD_BITS-1:0] held_qx_q, held_qy_q;
	logic signed [W-1:0]          start_x_q, start_y_q;
	logic signed [W-1:0]          prior_x_q, prior_y_q;

	logic signed [COORD_BITS-1:0] qx, qy;
	logic signed [W-1:0]          cur_x, cur_y, start_x_nx, start_y_nx;
	logic                         ready1, ready2, adv1;

	assign ready2    = !ctl_s2.valid || ready3;
	assign ready1    = !ctl_s1.valid || ready2;
	assign adv1      = ctl_s1.valid && ready2;
	assign vtx.ready = ready1;

	// the first vertex brings its own query point
	assign qx = ctl_s1.first ? qx_s1 : held_qx_q;
	assign qy = ctl_s1.first ? qy_s1 : held_qy_q;

	assign cur_x = $signed({vx_s1[COORD_BITS-1], vx_s1}) - $signed({qx[COORD_BITS-1], qx});
	assign cur_y = $signed({vy_s1[COORD_BITS-1], vy_s1}) - $signed({qy[COORD_BITS-1], qy});

	assign start_x_nx = ctl_s1.first ? cur_x : start_x_q;
	assign start_y_nx = ctl_s1.first ? cur_y : start_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else begin
			if (ready1) begin
				ctl_s1 <= '{valid: vtx.valid, first: vtx.first_vertex, last: vtx.last_vertex};
			end
			if (ready2) begin
				ctl_s2 <= ctl_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready1 && vtx.valid) begin
			qx_s1 <= vtx.query_x;
			qy_s1 <= vtx.query_y;
			vx_s1 <= vtx.vertex_x;
			vy_s1 <= vtx.vertex_y;
		end
		if (adv1) begin
			cur_x_s2 <= cur_x;
			cur_y_s2 <= cur_y;
			prv_x_s2 <= prior_x_q;
			prv_y_s2 <= prior_y_q;
			st_x_s2  <= start_x_nx;
			st_y_s2  <= start_y_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_qx_q <= '0;
			held_qy_q <= '0;
			start_x_q <= '0;
			start_y_q <= '0;
			prior_x_q <= '0;
			prior_y_q <= '0;
		end else if (adv1) begin
			if (ctl_s1.first) begin
				held_qx_q <= qx_s1;
				held_qy_q <= qy_s1;
			end
			start_x_q <= start_x_nx;
			start_y_q <= start_y_nx;
			prior_x_q <= cur_x;
			prior_y_q <= cur_y;
		end
	end

`ifndef SYNTH
	// a first vertex equal to its own query point enters the pipeline at the origin
	a_first_at_origin: assert property (@(posedge clk) disable iff (!arst_n)
		adv1 && ctl_s1.first && vx_s1 == qx_s1 && vy_s1 == qy_s1 |=>
			st_x_s2 == '0 && st_y_s2 == '0)
		else $error("first vertex equal to query not translated to origin");
`endif

endmodule

`default_nettype wire

// ===== design/pipc_edge_prod.sv =====
// pipc_edge_prod: cross-term products and end signs of one polygon edge
// depends on pipc_pkg
`default_nettype none

module pipc_edge_prod import pipc_pkg::*; #(
	parameter int W = 33
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic signed [W-1:0]   p_x,
	input  logic signed [W-1:0]   p_y,
	input  logic signed [W-1:0]   q_x,
	input  logic signed [W-1:0]   q_y,
	output logic signed [2*W-1:0] prod_a_s3,
	output logic signed [2*W-1:0] prod_b_s3,
	output edge_sign_t            sign_s3
);

	logic signed [2*W-1:0] prod_a, prod_b;

	// full width signed products, exact
	assign prod_a = p_x * q_y;
	assign prod_b = q_x * p_y;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_a_s3 <= prod_a;
			prod_b_s3 <= prod_b;
			sign_s3   <= '{x1n: p_x[W-1], x2n: q_x[W-1], y1n: p_y[W-1], y2n: q_y[W-1]};
		end
	end

endmodule

`default_nettype wire

// ===== design/pipc_count.sv =====
// pipc_count: crossing decision, parity accumulation and the result register
// depends on pipc_pkg and pipc_out_if
`default_nettype none

module pipc_count import pipc_pkg::*; #(
	parameter int W = 33
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pipc_ctl_t             ctl_s2,
	output logic                  ready3,
	input  logic signed [2*W-1:0] chain_a_s3,
	input  logic signed [2*W-1:0] chain_b_s3,
	input  edge_sign_t            chain_sign_s3,
	input  logic signed [2*W-1:0] close_a_s3,
	input  logic signed [2*W-1:0] close_b_s3,
	input  edge_sign_t            close_sign_s3,
	pipc_out_if.source            res
);

	pipc_ctl_t ctl_s3;
	logic      parity_q;
	logic      out_valid_q;
	logic      inside_q;
	logic      adv3;
	logic      chain_hit, close_hit, parity_nx;

	// only an item that closes a polygon needs the result register
	assign adv3   = ctl_s3.valid && (!ctl_s3.last || !out_valid_q || res.ready);
	assign ready3 = !ctl_s3.valid || adv3;

	assign chain_hit = edge_verdict(chain_sign_s3, chain_a_s3 >= chain_b_s3,
		chain_a_s3 <= chain_b_s3);
	assign close_hit = edge_verdict(close_sign_s3, close_a_s3 >= close_b_s3,
		close_a_s3 <= close_b_s3);

	// a first vertex restarts the chain and has no incoming edge
	assign parity_nx = ctl_s3.first ? 1'b0 : (parity_q ^ chain_hit);

	assign res.valid      = out_valid_q;
	assign res.inside_res = inside_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3      <= '0;
			parity_q    <= 1'b0;
			out_valid_q <= 1'b0;
			inside_q    <= 1'b0;
		end else begin
			if (ready3) begin
				ctl_s3 <= ctl_s2;
			end
			if (adv3) begin
				parity_q <= parity_nx;
			end
			if (adv3 && ctl_s3.last) begin
				out_valid_q <= 1'b1;
				inside_q    <= parity_nx ^ close_hit;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTH
	// the last stage holds only behind an untaken result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s3.valid && !adv3 |-> ctl_s3.last && out_valid_q && !res.ready)
		else $error("last stage stalled without a pending result");

	// a new result comes only from a closing vertex
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(adv3 && ctl_s3.last))
		else $error("result raised without a closing vertex");

	// a polygon of one vertex is never inside
	a_single_vertex: assert property (@(posedge clk) disable iff (!arst_n)
		adv3 && ctl_s3.first && ctl_s3.last |=> out_valid_q && !inside_q)
		else $error("single vertex polygon reported inside");
`endif

endmodule

`default_nettype wire

// ===== design/point_in_polygon_crossing_top.sv =====
// point_in_polygon_crossing_top: crossing-number point-in-polygon test over a vertex stream
// depends on pipc_pkg, pipc_in_if, pipc_out_if, pipc_front, pipc_edge_prod, pipc_count
`default_nettype none

// One polygon vertex is taken per transfer, one per cycle unless stalled. A vertex marked first
// also carries the query point and starts a new polygon; a vertex marked last closes the
// polygon back to its first vertex and produces one result transfer: inside_res is 1 when
// the number of edges crossing the positive x ray from the query point is odd. Coordinates
// are signed Q16.16, COORD_BITS wide, and the test is exact. A closing vertex passes the input
// register, translation register and product register, then the result register. The only
// throttle is the single result register: a closing vertex waits in the last stage while an
// earlier result has not been taken, and the pipeline behind it stops; vertices that close
// nothing keep moving.
module point_in_polygon_crossing_top import pipc_pkg::*; #(
	parameter int COORD_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	pipc_in_if.sink    vtx,
	pipc_out_if.source res
);

	localparam int W = COORD_BITS + 1;

	pipc_ctl_t             ctl_s2;
	logic                  ready3;
	logic signed [W-1:0]   cur_x_s2, cur_y_s2, prv_x_s2, prv_y_s2, st_x_s2, st_y_s2;
	logic signed [2*W-1:0] chain_a_s3, chain_b_s3, close_a_s3, close_b_s3;
	edge_sign_t            chain_sign_s3, close_sign_s3;
	logic                  prod_en;

	assign prod_en = ready3 && ctl_s2.valid;

	pipc_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.vtx      (vtx),
		.ready3   (ready3),
		.ctl_s2   (ctl_s2),
		.cur_x_s2 (cur_x_s2),
		.cur_y_s2 (cur_y_s2),
		.prv_x_s2 (prv_x_s2),
		.prv_y_s2 (prv_y_s2),
		.st_x_s2  (st_x_s2),
		.st_y_s2  (st_y_s2)
	);

	// edge from the previous vertex to this one
	pipc_edge_prod #(
		.W(W)
	) u_chain_prod (
		.clk       (clk),
		.en        (prod_en),
		.p_x       (prv_x_s2),
		.p_y       (prv_y_s2),
		.q_x       (cur_x_s2),
		.q_y       (cur_y_s2),
		.prod_a_s3 (chain_a_s3),
		.prod_b_s3 (chain_b_s3),
		.sign_s3   (chain_sign_s3)
	);

	// closing edge from this vertex back to the first one
	pipc_edge_prod #(
		.W(W)
	) u_close_prod (
		.clk       (clk),
		.en        (prod_en),
		.p_x       (cur_x_s2),
		.p_y       (cur_y_s2),
		.q_x       (st_x_s2),
		.q_y       (st_y_s2),
		.prod_a_s3 (close_a_s3),
		.prod_b_s3 (close_b_s3),
		.sign_s3   (close_sign_s3)
	);

	pipc_count #(
		.W(W)
	) u_count (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl_s2        (ctl_s2),
		.ready3        (ready3),
		.chain_a_s3    (chain_a_s3),
		.chain_b_s3    (chain_b_s3),
		.chain_sign_s3 (chain_sign_s3),
		.close_a_s3    (close_a_s3),
		.close_b_s3    (close_b_s3),
		.close_sign_s3 (close_sign_s3),
		.res           (res)
	);

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// tb_top: stimulus, prediction and checking for point_in_polygon_crossing_top
// depends on pipc_in_if, pipc_out_if and point_in_polygon_crossing_top
// polygons stream in as vertex transfers; each closing vertex is checked by a parity predictor
`default_nettype none

module tb_top;

	localparam int CW = 32;

	typedef logic signed [CW-1:0] crd_t;
	// coordinate after translation by the query point, one bit wider
	typedef logic signed [CW:0] mv_t;

	typedef struct packed {
		crd_t qx;
		crd_t qy;
		crd_t vx;
		crd_t vy;
		logic opens;
		logic closes;
	} vtx_item_t;

	localparam crd_t U    = 32'sh0001_0000;
	localparam crd_t CMAX = {1'b0, {(CW-1){1'b1}}};
	localparam crd_t CMIN = {1'b1, {(CW-1){1'b0}}};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	pipc_in_if #(.COORD_BITS(CW)) vtx ();
	pipc_out_if res ();

	vtx_item_t in_item = '0;
	logic in_valid = 1'b0;
	logic res_rdy = 1'b0;
	logic hold_rx = 1'b0;

	assign vtx.valid        = in_valid;
	assign vtx.query_x      = in_item.qx;
	assign vtx.query_y      = in_item.qy;
	assign vtx.vertex_x     = in_item.vx;
	assign vtx.vertex_y     = in_item.vy;
	assign vtx.first_vertex = in_item.opens;
	assign vtx.last_vertex  = in_item.closes;
	assign res.ready        = res_rdy;

	point_in_polygon_crossing_top #(.COORD_BITS(CW)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.vtx    (vtx),
		.res    (res)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#3_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// ---------------- crossing parity model ----------------

	crd_t held_qx = '0;
	crd_t held_qy = '0;
	mv_t  open_x = '0;
	mv_t  open_y = '0;
	mv_t  prev_x = '0;
	mv_t  prev_y = '0;
	logic odd_edges = 1'b0;
	logic inside_q[$];

	// edge a->b against the closed positive x half-axis
	function automatic logic crosses_ray(mv_t ax, mv_t ay, mv_t bx, mv_t by);
		logic signed [2*CW+1:0] ab;
		logic signed [2*CW+1:0] ba;
		ab = ax * by;
		ba = bx * ay;
		if (ax[CW] && bx[CW]) return 1'b0;
		if (ay[CW] == by[CW]) return 1'b0;
		if (!ax[CW] && !bx[CW]) return 1'b1;
		// mixed signs: intercept sign follows the cross term and the direction in y
		if (ay[CW]) return ab >= ba;
		return ab <= ba;
	endfunction

	task automatic track_vertex(input vtx_item_t it);
		mv_t cx;
		mv_t cy;
		if (it.opens) begin
			held_qx = it.qx;
			held_qy = it.qy;
		end
		cx = {it.vx[CW-1], it.vx} - {held_qx[CW-1], held_qx};
		cy = {it.vy[CW-1], it.vy} - {held_qy[CW-1], held_qy};
		if (it.opens) begin
			open_x = cx;
			open_y = cy;
			odd_edges = 1'b0;
		end else begin
			odd_edges ^= crosses_ray(prev_x, prev_y, cx, cy);
		end
		prev_x = cx;
		prev_y = cy;
		if (it.closes)
			inside_q.push_back(odd_edges ^ crosses_ray(cx, cy, open_x, open_y));
	endtask

	// ---------------- checking ----------------

	int n_errs = 0;
	int vtx_taken = 0;

	task automatic flag_mismatch(input string msg);
		$display("mismatch @%0t: %s", $time, msg);
		n_errs++;
	endtask

	always @(posedge clk) begin
		vtx_item_t seen;
		logic want;
		if (arst_n) begin
			if (res.valid && res.ready) begin
				if (inside_q.size() == 0) begin
					flag_mismatch($sformatf("inside_res=%0b with no result pending",
						res.inside_res));
				end else begin
					want = inside_q.pop_front();
					if (res.inside_res !== want)
						flag_mismatch($sformatf("inside_res=%0b, want %0b", res.inside_res, want));
				end
			end
			if (vtx.valid && vtx.ready) begin
				seen.qx = vtx.query_x;
				seen.qy = vtx.query_y;
				seen.vx = vtx.vertex_x;
				seen.vy = vtx.vertex_y;
				seen.opens = vtx.first_vertex;
				seen.closes = vtx.last_vertex;
				track_vertex(seen);
				vtx_taken++;
			end
		end
	end

	// ---------------- vertex driver ----------------

	vtx_item_t vtx_pend_q[$];
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else if (!in_valid || vtx.ready) begin
			if (gap_left != 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (vtx_pend_q.size() != 0) begin
				in_item <= vtx_pend_q.pop_front();
				in_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
						: $urandom_range(1, 16);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left--;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ---------------- result receiver ----------------

	logic [15:0] rdy_pat = '1;
	int unsigned rdy_idx = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_rdy <= 1'b0;
			rdy_idx = 0;
		end else begin
			if (rdy_idx == 0) begin
				case ($urandom_range(0, 3))
					0: rdy_pat = '1;
					1: rdy_pat = 16'($urandom);
					2: rdy_pat = 16'($urandom | $urandom);
					default: rdy_pat = 16'($urandom & $urandom) | 16'h0001;
				endcase
			end
			res_rdy <= !hold_rx && rdy_pat[rdy_idx];
			rdy_idx = (rdy_idx + 1) % 16;
		end
	end

	// long receiver hold-off once traffic is flowing, so the pipeline backs up
	initial begin
		while (vtx_taken < 300) @(posedge clk);
		hold_rx <= 1'b1;
		repeat (400) @(posedge clk);
		hold_rx <= 1'b0;
	end

	// ---------------- stimulus ----------------

	task automatic add_vtx(input crd_t qx, input crd_t qy, input crd_t vx, input crd_t vy,
			input logic o, input logic c);
		vtx_item_t it;
		it.qx = qx;
		it.qy = qy;
		it.vx = vx;
		it.vy = vy;
		it.opens = o;
		it.closes = c;
		vtx_pend_q.push_back(it);
	endtask

	function automatic crd_t rand_coord();
		case ($urandom_range(0, 7))
			0: return CMAX;
			1: return CMIN;
			2: return '0;
			3: return '1;
			default: return crd_t'($urandom);
		endcase
	endfunction

	// vertex offset from the query: mostly near it so edges straddle the ray
	function automatic crd_t rand_offset();
		case ($urandom_range(0, 9))
			0: return '0;
			1, 2: return crd_t'((int'($urandom_range(0, 16)) - 8) * U);
			3, 4: return crd_t'(int'($urandom_range(0, 8)) - 4);
			5, 6, 7: return crd_t'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
			8: return crd_t'($urandom);
			default: return rand_coord();
		endcase
	endfunction

	task automatic add_polygon(input int n, input logic closed);
		crd_t qx;
		crd_t qy;
		qx = ($urandom_range(0, 3) == 0) ? rand_coord() : crd_t'($urandom);
		qy = ($urandom_range(0, 3) == 0) ? rand_coord() : crd_t'($urandom);
		add_vtx(qx, qy, qx + rand_offset(), qy + rand_offset(), 1'b1, closed && n == 1);
		for (int i = 1; i < n; i++)
			add_vtx(crd_t'($urandom), crd_t'($urandom), qx + rand_offset(), qy + rand_offset(),
				1'b0, closed && i == n - 1);
	endtask

	task automatic add_noise();
		int k;
		case ($urandom_range(0, 2))
			0: add_vtx(crd_t'($urandom), crd_t'($urandom), crd_t'($urandom), crd_t'($urandom),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			1: begin
				// more vertices on whatever polygon is open, possibly closing it again
				k = $urandom_range(1, 4);
				for (int j = 0; j < k; j++)
					add_vtx(crd_t'($urandom), crd_t'($urandom), rand_coord(), rand_coord(),
						1'b0, j == k - 1);
			end
			default: add_polygon($urandom_range(1, 5), 1'b0);
		endcase
	endtask

	initial begin
		// vertices before any polygon start run against the zero state
		add_vtx(5*U, -3*U, U, -U, 1'b0, 1'b0);
		add_vtx(-7*U, 2*U, 2*U, U, 1'b0, 1'b1);
		// single-vertex polygon at the coordinate extremes
		add_vtx(CMIN, CMAX, CMAX, CMIN, 1'b1, 1'b1);
		// square around the query
		add_vtx(3*U, 3*U, 4*U, 2*U, 1'b1, 1'b0);
		add_vtx(0, 0, 4*U, 4*U, 1'b0, 1'b0);
		add_vtx(0, 0, 2*U, 4*U, 1'b0, 1'b0);
		add_vtx(0, 0, 2*U, 2*U, 1'b0, 1'b1);
		// far corners: translations span the full widened range
		add_vtx(CMIN, CMIN, CMAX, CMIN, 1'b1, 1'b0);
		add_vtx(0, 0, CMAX, CMAX, 1'b0, 1'b0);
		add_vtx(0, 0, CMIN, CMAX, 1'b0, 1'b1);
		add_vtx(CMAX, CMAX, CMIN, CMIN, 1'b1, 1'b0);
		add_vtx(0, 0, CMIN, CMAX, 1'b0, 1'b0);
		add_vtx(0, 0, CMAX, CMIN, 1'b0, 1'b1);
		// edge through the query point, then vertices after the close
		add_vtx(U, U, 0, 0, 1'b1, 1'b0);
		add_vtx(0, 0, 2*U, 2*U, 1'b0, 1'b0);
		add_vtx(0, 0, -U, 2*U, 1'b0, 1'b1);
		add_vtx(0, 0, 2*U, 0, 1'b0, 1'b0);
		add_vtx(0, 0, 2*U, 3*U, 1'b0, 1'b1);
		// diamond with corners on both axes
		add_vtx(-U, -U, 0, -U, 1'b1, 1'b0);
		add_vtx(0, 0, -U, 0, 1'b0, 1'b0);
		add_vtx(0, 0, -2*U, -U, 1'b0, 1'b0);
		add_vtx(0, 0, -U, -2*U, 1'b0, 1'b1);

		while (vtx_pend_q.size() < 1050) begin
			if ($urandom_range(0, 99) < 85)
				add_polygon(($urandom_range(0, 9) == 0) ? $urandom_range(9, 24)
					: $urandom_range(1, 8), 1'b1);
			else
				add_noise();
		end

		while (!arst_n) @(posedge clk);
		while (vtx_pend_q.size() != 0 || in_valid) @(posedge clk);
		while (inside_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (n_errs == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
design/pipc_pkg.sv
design/pipc_in_if.sv
design/pipc_out_if.sv
design/pipc_front.sv
design/pipc_edge_prod.sv
design/pipc_count.sv
design/point_in_polygon_crossing_top.sv
tb/sv/tb_top.sv
